// ===== rtl/core/sag_pkg.sv =====
`default_nettype none

package sag_pkg;

    // Verdict reason codes.
    localparam logic [2:0] WHY_HOLDOFF      = 3'd0;
    localparam logic [2:0] WHY_ICMP_ECHO    = 3'd1;
    localparam logic [2:0] WHY_LOOPBACK     = 3'd2;
    localparam logic [2:0] WHY_UNFILTERED   = 3'd3;
    localparam logic [2:0] WHY_BAD_LENGTH   = 3'd4;
    localparam logic [2:0] WHY_RATE_LIMITED = 3'd5;
    localparam logic [2:0] WHY_OTP_GOOD     = 3'd6;
    localparam logic [2:0] WHY_OTP_BAD      = 3'd7;

    // Protocol kinds.
    localparam logic [1:0] PROTO_OTHER = 2'd0;
    localparam logic [1:0] PROTO_ICMP  = 2'd1;
    localparam logic [1:0] PROTO_TCP   = 2'd2;
    localparam logic [1:0] PROTO_UDP   = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_HOLDOFF_MS    = 3'd0;
    localparam logic [2:0] REG_UDP_ENABLE    = 3'd1;
    localparam logic [2:0] REG_RATE_ENABLE   = 3'd2;
    localparam logic [2:0] REG_OTP_LENGTH    = 3'd3;
    localparam logic [2:0] REG_KNOCK_ENABLE  = 3'd4;
    localparam logic [2:0] REG_KNOCK_FIRST   = 3'd5;
    localparam logic [2:0] REG_KNOCK_FIFTH   = 3'd6;

    // Fixed constants.
    localparam logic [31:0] LOOP_LOW      = 32'd2130706432;
    localparam logic [31:0] LOOP_HIGH     = 32'd2147483647;
    localparam logic [47:0] WINDOW_MS     = 48'd1000;
    localparam logic [31:0] HOLDOFF_RESET = 32'd10000;
    localparam logic [2:0]  KNOCK_LAST    = 3'd4;
    localparam logic [2:0]  KNOCK_DONE    = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/core/syn_admission_gate_top.sv =====
// An accepted transaction waits in the input register; its verdict goes to the result register.
// Throughput: one transaction per cycle unless the output stalls; the verdict and all state
// updates are made in a single pass between the input register and the result register.
// A stalled output holds its result; the input stalls only once both registers are full.
// Reset: rst_n is asynchronous and active low; it clears the pipeline, the knock tracker
// and the rate timer, arms the hold-off from time zero and loads the register defaults.
`default_nettype none

module syn_admission_gate_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [47:0] now_ms,
    input  wire logic [31:0] src_addr,
    input  wire logic [1:0]  proto_kind,
    input  wire logic        icmp_is_echo,
    input  wire logic        syn_flag,
    input  wire logic        ack_flag,
    input  wire logic [15:0] dest_port,
    input  wire logic [15:0] payload_bytes,
    input  wire logic        udp_new_flow,
    input  wire logic        otp_ok,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             drop,
    output logic      [2:0]  why
);
    import sag_pkg::*;

    // Configuration registers
    logic [31:0] holdoff_ms_reg;
    logic        udp_enable_reg;
    logic        rate_enable_reg;
    logic [15:0] otp_length_reg;
    logic        knock_enable_reg;
    logic [63:0] knock_first_reg;
    logic [15:0] knock_fifth_reg;

    logic [2:0]  cfg_index;
    logic        cfg_write;

    // Input register
    logic        s1_valid_reg;
    logic [47:0] now_reg;
    logic [31:0] src_reg;
    logic [1:0]  proto_reg;
    logic        echo_reg;
    logic        syn_reg;
    logic        ack_reg;
    logic [15:0] port_reg;
    logic [15:0] len_reg;
    logic        newflow_reg;
    logic        ok_reg;

    // Result register
    logic        out_valid_reg;
    logic        drop_reg;
    logic [2:0]  why_reg;

    // Block state
    logic        holdoff_active_reg;
    logic        holdoff_active_next;
    logic [47:0] holdoff_start_reg;
    logic [47:0] holdoff_start_next;
    logic [2:0]  knock_step_reg;
    logic [2:0]  knock_step_next;
    logic [47:0] knock_start_reg;
    logic [47:0] knock_start_next;
    logic [31:0] knock_source_reg;
    logic [31:0] knock_source_next;
    logic [47:0] last_check_reg;
    logic [47:0] last_check_next;

    // Handshake
    logic        advance;
    logic        accept;
    logic        process;

    // Verdict logic
    logic [47:0] hold_elapsed;
    logic [47:0] knock_elapsed;
    logic [47:0] check_elapsed;
    logic        in_hold;
    logic        is_echo;
    logic        is_loop;
    logic        tcp_syn;
    logic        udp_check;
    logic        filtered;
    logic        len_ok;
    logic        rate_hit;
    logic        knock_run;
    logic        knock_fire;
    logic [2:0]  step_eff;
    logic [2:0]  step_inc;
    logic [15:0] knock_port;
    logic [2:0]  why_next;
    logic        drop_next;

    assign pready    = 1'b1;
    assign cfg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_ms_reg   <= HOLDOFF_RESET;
            udp_enable_reg   <= 1'b0;
            rate_enable_reg  <= 1'b0;
            otp_length_reg   <= 16'd0;
            knock_enable_reg <= 1'b0;
            knock_first_reg  <= 64'd0;
            knock_fifth_reg  <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HOLDOFF_MS:   holdoff_ms_reg   <= pwdata[31:0];
                REG_UDP_ENABLE:   udp_enable_reg   <= pwdata[0];
                REG_RATE_ENABLE:  rate_enable_reg  <= pwdata[0];
                REG_OTP_LENGTH:   otp_length_reg   <= pwdata[15:0];
                REG_KNOCK_ENABLE: knock_enable_reg <= pwdata[0];
                REG_KNOCK_FIRST:  knock_first_reg  <= pwdata;
                REG_KNOCK_FIFTH:  knock_fifth_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        unique case (cfg_index)
            REG_HOLDOFF_MS:   prdata = {32'd0, holdoff_ms_reg};
            REG_UDP_ENABLE:   prdata = {63'd0, udp_enable_reg};
            REG_RATE_ENABLE:  prdata = {63'd0, rate_enable_reg};
            REG_OTP_LENGTH:   prdata = {48'd0, otp_length_reg};
            REG_KNOCK_ENABLE: prdata = {63'd0, knock_enable_reg};
            REG_KNOCK_FIRST:  prdata = knock_first_reg;
            REG_KNOCK_FIFTH:  prdata = {48'd0, knock_fifth_reg};
            default:          prdata = 64'd0;
        endcase
    end

    // The result register moves on when empty or taken; the input register refills behind it.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign process  = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Input payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg     <= now_ms;
            src_reg     <= src_addr;
            proto_reg   <= proto_kind;
            echo_reg    <= icmp_is_echo;
            syn_reg     <= syn_flag;
            ack_reg     <= ack_flag;
            port_reg    <= dest_port;
            len_reg     <= payload_bytes;
            newflow_reg <= udp_new_flow;
            ok_reg      <= otp_ok;
        end
    end

    // Elapsed times wrap modulo the 48-bit time base.
    assign hold_elapsed  = now_reg - holdoff_start_reg;
    assign knock_elapsed = now_reg - knock_start_reg;
    assign check_elapsed = now_reg - last_check_reg;

    // Classification of the transaction in the input register.
    assign in_hold   = holdoff_active_reg && (hold_elapsed < {16'd0, holdoff_ms_reg});
    assign is_echo   = (proto_reg == PROTO_ICMP) && echo_reg;
    assign is_loop   = (src_reg >= LOOP_LOW) && (src_reg <= LOOP_HIGH);
    assign tcp_syn   = (proto_reg == PROTO_TCP) && syn_reg && !ack_reg;
    assign udp_check = (proto_reg == PROTO_UDP) && udp_enable_reg && newflow_reg;
    assign filtered  = !in_hold && !is_echo && !is_loop && (tcp_syn || udp_check);
    assign len_ok    = tcp_syn ? (len_reg == otp_length_reg) : (len_reg > otp_length_reg);
    assign rate_hit  = rate_enable_reg && (check_elapsed < WINDOW_MS);

    // Verdict in order of precedence.
    always_comb
    begin
        priority if (in_hold)
            why_next = WHY_HOLDOFF;
        else if (is_echo)
            why_next = WHY_ICMP_ECHO;
        else if (is_loop)
            why_next = WHY_LOOPBACK;
        else if (!filtered)
            why_next = WHY_UNFILTERED;
        else if (!len_ok)
            why_next = WHY_BAD_LENGTH;
        else if (rate_hit)
            why_next = WHY_RATE_LIMITED;
        else if (ok_reg)
            why_next = WHY_OTP_GOOD;
        else
            why_next = WHY_OTP_BAD;
    end

    assign drop_next = (why_next == WHY_ICMP_ECHO) || (why_next == WHY_BAD_LENGTH)
                    || (why_next == WHY_RATE_LIMITED) || (why_next == WHY_OTP_BAD);

    // Knock tracker: a stale or overrun sequence restarts before the port is matched.
    assign knock_run = filtered && tcp_syn && knock_enable_reg;

    always_comb
    begin
        if ((knock_step_reg != 3'd0) && (knock_elapsed > WINDOW_MS))
            step_eff = 3'd0;
        else if (knock_step_reg > KNOCK_LAST)
            step_eff = 3'd0;
        else
            step_eff = knock_step_reg;
    end

    assign step_inc = step_eff + 3'd1;

    always_comb
    begin
        unique case (step_eff)
            3'd0:    knock_port = knock_first_reg[15:0];
            3'd1:    knock_port = knock_first_reg[31:16];
            3'd2:    knock_port = knock_first_reg[47:32];
            3'd3:    knock_port = knock_first_reg[63:48];
            default: knock_port = knock_fifth_reg;
        endcase
    end

    assign knock_fire = knock_run && (port_reg == knock_port) && (step_eff != 3'd0)
                     && (src_reg == knock_source_reg) && (step_inc == KNOCK_DONE);

    // Next state for the knock tracker, hold-off and rate timer.
    always_comb
    begin
        knock_step_next     = knock_step_reg;
        knock_start_next    = knock_start_reg;
        knock_source_next   = knock_source_reg;
        holdoff_active_next = holdoff_active_reg && in_hold;
        holdoff_start_next  = holdoff_start_reg;
        last_check_next     = last_check_reg;

        if (knock_run)
        begin
            if (step_eff != knock_step_reg)
            begin
                knock_step_next   = 3'd0;
                knock_start_next  = 48'd0;
                knock_source_next = 32'd0;
            end
            if (port_reg == knock_port)
            begin
                if (step_eff == 3'd0)
                begin
                    knock_step_next   = 3'd1;
                    knock_start_next  = now_reg;
                    knock_source_next = src_reg;
                end
                else if (knock_fire)
                begin
                    knock_step_next     = 3'd0;
                    knock_start_next    = 48'd0;
                    knock_source_next   = 32'd0;
                    holdoff_active_next = 1'b1;
                    holdoff_start_next  = now_reg;
                end
                else if (src_reg == knock_source_reg)
                begin
                    knock_step_next = step_inc;
                end
            end
        end

        if (filtered && len_ok && rate_enable_reg)
        begin
            last_check_next = now_reg;
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_active_reg <= 1'b1;
            holdoff_start_reg  <= 48'd0;
            knock_step_reg     <= 3'd0;
            knock_start_reg    <= 48'd0;
            knock_source_reg   <= 32'd0;
            last_check_reg     <= 48'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                holdoff_active_reg <= holdoff_active_next;
                holdoff_start_reg  <= holdoff_start_next;
                knock_step_reg     <= knock_step_next;
                knock_start_reg    <= knock_start_next;
                knock_source_reg   <= knock_source_next;
                last_check_reg     <= last_check_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            drop_reg <= drop_next;
            why_reg  <= why_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drop      = drop_reg;
    assign why       = why_reg;

    // The tracker never rests beyond the last knock step.
    assert property (@(posedge clk) disable iff (!rst_n) knock_step_reg <= KNOCK_LAST)
        else $error("knock tracker beyond last step");

    // A completed knock re-arms the hold-off.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && knock_fire) |=> holdoff_active_reg)
        else $error("completed knock did not re-arm hold-off");

    // The drop flag agrees with the reason code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drop_reg == ((why_reg == WHY_ICMP_ECHO)
            || (why_reg == WHY_BAD_LENGTH) || (why_reg == WHY_RATE_LIMITED)
            || (why_reg == WHY_OTP_BAD))))
        else $error("drop flag disagrees with reason");

    // The input side only stalls while its register holds a transaction.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire

// ===== tb/syn_admission_gate_top_tb.sv =====
module syn_admission_gate_top_tb;
    import sag_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 250;
    localparam logic [2:0]  REG_UNUSED      = 3'd7;

    typedef struct packed {
        logic [47:0] now_ms;
        logic [31:0] src_addr;
        logic [1:0]  proto_kind;
        logic        icmp_is_echo;
        logic        syn_flag;
        logic        ack_flag;
        logic [15:0] dest_port;
        logic [15:0] payload_bytes;
        logic        udp_new_flow;
        logic        otp_ok;
    } pkt_t;

    typedef struct packed {
        logic       drop;
        logic [2:0] why;
    } verdict_t;

    // Scoreboard: keeps its own copy of the gate's registers and state, works out the
    // verdict of every accepted packet and compares the verdicts that come back in order.
    class admission_scoreboard;
        logic [31:0] cfg_holdoff_ms;
        logic        cfg_udp_en;
        logic        cfg_rate_en;
        logic [15:0] cfg_otp_len;
        logic        cfg_knock_en;
        logic [63:0] cfg_knock_first;
        logic [15:0] cfg_knock_fifth;
        logic        armed;
        logic [47:0] arm_time;
        logic [2:0]  knock_stage;
        logic [47:0] knock_t0;
        logic [31:0] knock_src;
        logic [47:0] last_otp_time;
        verdict_t    verdicts_due[$];
        int unsigned faults;

        function new();
            cfg_holdoff_ms  = HOLDOFF_RESET;
            cfg_udp_en      = 1'b0;
            cfg_rate_en     = 1'b0;
            cfg_otp_len     = 16'd0;
            cfg_knock_en    = 1'b0;
            cfg_knock_first = 64'd0;
            cfg_knock_fifth = 16'd0;
            armed           = 1'b1;
            arm_time        = 48'd0;
            last_otp_time   = 48'd0;
            faults          = 0;
            clear_knock();
        endfunction

        function void set_register(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_HOLDOFF_MS:   cfg_holdoff_ms  = value[31:0];
                REG_UDP_ENABLE:   cfg_udp_en      = value[0];
                REG_RATE_ENABLE:  cfg_rate_en     = value[0];
                REG_OTP_LENGTH:   cfg_otp_len     = value[15:0];
                REG_KNOCK_ENABLE: cfg_knock_en    = value[0];
                REG_KNOCK_FIRST:  cfg_knock_first = value;
                REG_KNOCK_FIFTH:  cfg_knock_fifth = value[15:0];
                default:          ;
            endcase
        endfunction

        function logic [15:0] port_at(logic [2:0] stage);
            if (stage < KNOCK_LAST)
                return cfg_knock_first[int'(stage) * 16 +: 16];
            return cfg_knock_fifth;
        endfunction

        function void clear_knock();
            knock_stage = 3'd0;
            knock_t0    = 48'd0;
            knock_src   = 32'd0;
        endfunction

        // Knock tracker: a stale sequence times out, a matching port starts it or, from the same
        // source, advances it, and the fifth port from the same source re-arms the hold-off.
        function void track_knock(logic [47:0] now, logic [15:0] port, logic [31:0] src);
            logic [47:0] gap;
            gap = now - knock_t0;
            if (knock_stage != 3'd0 && gap > WINDOW_MS)
                clear_knock();
            if (knock_stage > KNOCK_LAST)
                clear_knock();
            if (port != port_at(knock_stage))
                return;
            if (knock_stage == 3'd0)
            begin
                knock_src   = src;
                knock_t0    = now;
                knock_stage = 3'd1;
                return;
            end
            if (src == knock_src)
                knock_stage = knock_stage + 3'd1;
            if (knock_stage == KNOCK_DONE)
            begin
                armed    = 1'b1;
                arm_time = now;
                clear_knock();
            end
        endfunction

        // The rate timer is restarted by every check that reaches it, limited or not.
        function logic [2:0] otp_outcome(logic [47:0] now, logic ok);
            logic [47:0] gap;
            if (cfg_rate_en)
            begin
                gap           = now - last_otp_time;
                last_otp_time = now;
                if (gap < WINDOW_MS)
                    return WHY_RATE_LIMITED;
            end
            return ok ? WHY_OTP_GOOD : WHY_OTP_BAD;
        endfunction

        function verdict_t judge_packet(pkt_t p);
            verdict_t    v;
            logic [2:0]  reason;
            logic [47:0] gap;
            logic        held;
            reason = WHY_UNFILTERED;
            held   = 1'b0;
            if (armed)
            begin
                gap = p.now_ms - arm_time;
                if (gap >= {16'd0, cfg_holdoff_ms})
                    armed = 1'b0;
                else
                    held = 1'b1;
            end
            if (held)
                reason = WHY_HOLDOFF;
            else if (p.proto_kind == PROTO_ICMP && p.icmp_is_echo)
                reason = WHY_ICMP_ECHO;
            else if (p.src_addr >= LOOP_LOW && p.src_addr <= LOOP_HIGH)
                reason = WHY_LOOPBACK;
            else if (p.proto_kind == PROTO_TCP)
            begin
                if (p.syn_flag && !p.ack_flag)
                begin
                    if (cfg_knock_en)
                        track_knock(p.now_ms, p.dest_port, p.src_addr);
                    if (p.payload_bytes != cfg_otp_len)
                        reason = WHY_BAD_LENGTH;
                    else
                        reason = otp_outcome(p.now_ms, p.otp_ok);
                end
            end
            else if (p.proto_kind == PROTO_UDP)
            begin
                if (cfg_udp_en && p.udp_new_flow)
                begin
                    if (p.payload_bytes <= cfg_otp_len)
                        reason = WHY_BAD_LENGTH;
                    else
                        reason = otp_outcome(p.now_ms, p.otp_ok);
                end
            end
            v.why  = reason;
            v.drop = (reason == WHY_ICMP_ECHO) || (reason == WHY_BAD_LENGTH) ||
                     (reason == WHY_RATE_LIMITED) || (reason == WHY_OTP_BAD);
            return v;
        endfunction

        function void note_packet(pkt_t p);
            verdicts_due.push_back(judge_packet(p));
        endfunction

        function void check_verdict(logic got_drop, logic [2:0] got_why);
            verdict_t want;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: verdict drop=%0b why=%0d arrived with no packet outstanding",
                         $time, got_drop, got_why);
                faults++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got_drop !== want.drop)
            begin
                $display("%0t: drop expected %0b actual %0b", $time, want.drop, got_drop);
                faults++;
            end
            if (got_why !== want.why)
            begin
                $display("%0t: why expected %0d actual %0d", $time, want.why, got_why);
                faults++;
            end
        endfunction

        function int unsigned waiting();
            return verdicts_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [47:0] now_ms;
    logic [31:0] src_addr;
    logic [1:0]  proto_kind;
    logic        icmp_is_echo;
    logic        syn_flag;
    logic        ack_flag;
    logic [15:0] dest_port;
    logic [15:0] payload_bytes;
    logic        udp_new_flow;
    logic        otp_ok;
    logic        out_valid;
    logic        out_stall;
    logic        drop;
    logic [2:0]  why;

    admission_scoreboard sb;
    logic [47:0]         cur_ms;
    int unsigned         sent;
    int unsigned         cycles;
    bit                  calm;
    bit                  long_hold_req;

    syn_admission_gate_top DUT (.*);

    // Clock with a period of 20 time units.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Run limit in case the block stops answering.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Every transaction on the result side is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict(drop, why);
    end

    // Result side back-pressure: short random bursts, and one long hold on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = 79;
                out_stall     <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic pkt_t build_packet(logic [1:0] proto, logic [31:0] src, logic echo,
                                          logic syn, logic ack, logic [15:0] port,
                                          logic [15:0] len, logic fresh, logic ok);
        pkt_t p;
        p = '{cur_ms, src, proto, echo, syn, ack, port, len, fresh, ok};
        return p;
    endfunction

    function automatic pkt_t syn_to(logic [31:0] src, logic [15:0] port, logic [15:0] len,
                                    logic ok);
        return build_packet(PROTO_TCP, src, 1'b0, 1'b1, 1'b0, port, len, 1'b0, ok);
    endfunction

    // A random source outside the loopback range.
    function automatic logic [31:0] rand_remote();
        logic [31:0] v;
        v = $urandom;
        if (v[31:24] == LOOP_LOW[31:24])
            v[31] = 1'b1;
        return v;
    endfunction

    // Entirely random header summary, with sources around the loopback edges.
    function automatic pkt_t noise_packet();
        logic [31:0] src;
        case ($urandom_range(0, 9))
            0:       src = LOOP_LOW + 32'($urandom_range(0, 16777215));
            1:       src = LOOP_LOW;
            2:       src = LOOP_HIGH;
            3:       src = LOOP_LOW - 32'd1;
            4:       src = LOOP_HIGH + 32'd1;
            default: src = $urandom;
        endcase
        return build_packet(2'($urandom), src, 1'($urandom), 1'($urandom), 1'($urandom),
                            16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    endfunction

    // Time moves forward by a little, or by about one rate window.
    function automatic void step_time();
        if ($urandom_range(0, 3) == 0)
            cur_ms = cur_ms + 48'($urandom_range(900, 1100));
        else
            cur_ms = cur_ms + 48'($urandom_range(0, 300));
    endfunction

    function automatic logic [15:0] pick_port();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(20, 23));
    endfunction

    // Offer one packet, with an optional idle burst first, and wait for its transaction.
    task automatic offer(pkt_t p);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        {now_ms, src_addr, proto_kind, icmp_is_echo, syn_flag, ack_flag, dest_port,
         payload_bytes, udp_new_flow, otp_ok} <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_packet(p);
        sent++;
    endtask

    // Stop offering and wait until every verdict has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic set_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_gate(logic [31:0] holdoff, logic udp_en, logic rate_en,
                                logic [15:0] otp_len, logic knock_en,
                                logic [63:0] ports_first, logic [15:0] port_fifth);
        drain();
        set_reg(REG_HOLDOFF_MS, {32'd0, holdoff});
        set_reg(REG_UDP_ENABLE, {63'd0, udp_en});
        set_reg(REG_RATE_ENABLE, {63'd0, rate_en});
        set_reg(REG_OTP_LENGTH, {48'd0, otp_len});
        set_reg(REG_KNOCK_ENABLE, {63'd0, knock_en});
        set_reg(REG_KNOCK_FIRST, ports_first);
        set_reg(REG_KNOCK_FIFTH, {48'd0, port_fifth});
    endtask

    // A random episode: a knock sequence, a few one-time-password attempts, or noise.
    task automatic random_episode();
        logic [63:0] wide;
        logic [31:0] who;
        logic [15:0] len;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 3)
        begin
            wide   = {$urandom, $urandom};
            cur_ms = wide[47:0];
        end
        else if (kind < 5)
            cur_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000));
        kind = $urandom_range(0, 9);
        who  = rand_remote();
        if (kind < 4)
        begin
            for (int i = 0; i < 5; i++)
            begin
                step_time();
                if ($urandom_range(0, 7) == 0)
                    offer(syn_to(rand_remote(), sb.port_at(3'(i)), 16'($urandom), 1'($urandom)));
                len = $urandom_range(0, 1) ? sb.cfg_otp_len : 16'($urandom);
                if ($urandom_range(0, 9) == 0)
                    offer(syn_to(who, 16'($urandom), len, 1'($urandom)));
                else
                    offer(syn_to(who, sb.port_at(3'(i)), len, 1'($urandom)));
            end
        end
        else if (kind < 7)
        begin
            repeat ($urandom_range(1, 4))
            begin
                step_time();
                if ($urandom_range(0, 1))
                begin
                    len = ($urandom_range(0, 4) == 0) ? 16'($urandom) : sb.cfg_otp_len;
                    offer(syn_to(who, 16'($urandom), len, 1'($urandom)));
                end
                else
                begin
                    len = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                          sb.cfg_otp_len + 16'($urandom_range(0, 3));
                    offer(build_packet(PROTO_UDP, who, 1'b0, 1'b0, 1'b0, 16'($urandom), len,
                                       $urandom_range(0, 4) != 0, 1'($urandom)));
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                step_time();
                offer(noise_packet());
            end
        end
    endtask

    // Main sequence: reset, directed packets, then random phases under several settings.
    initial
    begin
        int unsigned phase_end;
        sb            = new();
        calm          = 1'b0;
        long_hold_req = 1'b0;
        sent          = 0;
        cur_ms        = 48'd0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        {now_ms, src_addr, proto_kind, icmp_is_echo, syn_flag, ack_flag, dest_port,
         payload_bytes, udp_new_flow, otp_ok} = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Start-up hold-off and its exact end, then the plain checks at reset settings.
        offer(syn_to(32'h0A00_0001, 16'd80, 16'd0, 1'b1));
        cur_ms = 48'd9999;
        offer(build_packet(PROTO_ICMP, 32'h0A00_0001, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0,
                           1'b0, 1'b0));
        cur_ms = 48'd10000;
        // An echo request from loopback is still dropped.
        offer(build_packet(PROTO_ICMP, 32'h7F00_0001, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0,
                           1'b0, 1'b0));
        offer(build_packet(PROTO_ICMP, 32'h0A00_0001, 1'b0, 1'b1, 1'b1, 16'd7, 16'd3,
                           1'b1, 1'b1));
        offer(build_packet(PROTO_OTHER, 32'h0A00_0001, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0,
                           1'b1, 1'b1));
        offer(syn_to(LOOP_LOW, 16'd0, 16'd0, 1'b1));
        offer(syn_to(LOOP_HIGH, 16'hFFFF, 16'd0, 1'b1));
        offer(syn_to(LOOP_LOW - 32'd1, 16'd443, 16'd0, 1'b1));
        offer(syn_to(LOOP_HIGH + 32'd1, 16'd443, 16'd0, 1'b0));
        offer(build_packet(PROTO_TCP, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'd0,
                           1'b1, 1'b1));
        offer(syn_to(32'h0A00_0001, 16'd443, 16'hFFFF, 1'b1));
        offer(build_packet(PROTO_UDP, 32'h0A00_0001, 1'b0, 1'b0, 1'b0, 16'd53, 16'd200,
                           1'b1, 1'b1));

        // New UDP flows, the rate limit, a knock with an intruder, and a knock timeout.
        program_gate(32'd3000, 1'b1, 1'b1, 16'd100, 1'b1,
                     {16'd1004, 16'd1003, 16'd1002, 16'd1001}, 16'd1005);
        cur_ms = 48'd10010;
        offer(build_packet(PROTO_UDP, 32'h0A00_0002, 1'b0, 1'b0, 1'b0, 16'd53, 16'd100,
                           1'b1, 1'b1));
        offer(build_packet(PROTO_UDP, 32'h0A00_0002, 1'b0, 1'b0, 1'b0, 16'd53, 16'd101,
                           1'b1, 1'b1));
        cur_ms = cur_ms + 48'd10;
        offer(build_packet(PROTO_UDP, 32'h0A00_0002, 1'b0, 1'b0, 1'b0, 16'd53, 16'hFFFF,
                           1'b1, 1'b0));
        offer(build_packet(PROTO_UDP, 32'h0A00_0002, 1'b0, 1'b0, 1'b0, 16'd53, 16'hFFFF,
                           1'b0, 1'b0));
        for (int i = 0; i < 5; i++)
        begin
            cur_ms = cur_ms + 48'd200;
            if (i == 2)
                offer(syn_to(32'h0A00_0099, sb.port_at(3'(i)), 16'd100, 1'b1));
            offer(syn_to(32'h0A00_0042, sb.port_at(3'(i)), 16'd100, 1'b1));
        end
        cur_ms = cur_ms + 48'd1;
        offer(build_packet(PROTO_ICMP, 32'h0A00_0001, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0,
                           1'b0, 1'b0));
        cur_ms = cur_ms + 48'd2999;
        offer(build_packet(PROTO_ICMP, 32'h0A00_0001, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0,
                           1'b0, 1'b0));
        cur_ms = cur_ms + 48'd10;
        offer(syn_to(32'h0A00_0042, 16'd1001, 16'd100, 1'b1));
        cur_ms = cur_ms + 48'd1001;
        offer(syn_to(32'h0A00_0042, 16'd1002, 16'd100, 1'b1));

        // Random phases; the last one runs without any idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                    program_gate(32'd0, 1'b1, 1'b1, 16'd0, 1'b1,
                                 {pick_port(), pick_port(), pick_port(), pick_port()},
                                 pick_port());
                2:
                begin
                    program_gate(32'hFFFF_FFFF, 1'b1, 1'b0, 16'hFFFF, 1'b1,
                                 {pick_port(), pick_port(), pick_port(), pick_port()},
                                 pick_port());
                    set_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                default:
                    program_gate($urandom_range(0, 3000), 1'($urandom), 1'($urandom),
                                 ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                                 16'($urandom_range(0, 200)),
                                 $urandom_range(0, 3) != 0,
                                 {pick_port(), pick_port(), pick_port(), pick_port()},
                                 pick_port());
            endcase
            if (ph == 3)
                long_hold_req = 1'b1;
            if (ph == 5)
                calm = 1'b1;
            phase_end = sent + ITEMS_PER_PHASE;
            while (sent < phase_end)
                random_episode();
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.faults == 0 && sb.waiting() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sag_pkg.sv
rtl/core/syn_admission_gate_top.sv
tb/syn_admission_gate_top_tb.sv
